/* rtl/pdc_pkg.sv */
// pdc_pkg: shared types, operand codes and the micro-program of the pose composer
// used by pdc_mac and pose_delta_composer_unit; depends on nothing
package pdc_pkg;

  localparam int unsigned PC_W = 7;
  localparam int unsigned ACC_W = 40;

  localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;

  // operand source codes
  localparam logic [4:0] SRC_Q1X = 5'd0;
  localparam logic [4:0] SRC_Q1Y = 5'd1;
  localparam logic [4:0] SRC_Q1Z = 5'd2;
  localparam logic [4:0] SRC_Q1W = 5'd3;
  localparam logic [4:0] SRC_Q2X = 5'd4;
  localparam logic [4:0] SRC_Q2Y = 5'd5;
  localparam logic [4:0] SRC_Q2Z = 5'd6;
  localparam logic [4:0] SRC_Q2W = 5'd7;
  localparam logic [4:0] SRC_P2X = 5'd8;
  localparam logic [4:0] SRC_P2Y = 5'd9;
  localparam logic [4:0] SRC_P2Z = 5'd10;
  localparam logic [4:0] SRC_NP2X = 5'd11;
  localparam logic [4:0] SRC_NP2Y = 5'd12;
  localparam logic [4:0] SRC_NP2Z = 5'd13;
  localparam logic [4:0] SRC_R1 = 5'd14;

  // operation codes
  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_COMPOSE = 2'd1;
  localparam logic [1:0] OP_COMPOSE_JAC = 2'd2;

  // program layout
  localparam logic [PC_W-1:0] PC_R2 = 7'd18;
  localparam logic [PC_W-1:0] PC_QUAT = 7'd36;
  localparam logic [PC_W-1:0] PC_POS_END = 7'd60;
  localparam logic [PC_W-1:0] PC_JAC_END = 7'd78;

  // result slots
  localparam logic [3:0] SLOT_POS = 4'd0;
  localparam logic [3:0] SLOT_QUAT = 4'd1;
  localparam logic [3:0] SLOT_JAC_LAST = 4'd10;
  localparam logic [3:0] N_COMPOSE = 4'd2;
  localparam logic [3:0] N_COMPOSE_JAC = 4'd11;

  typedef enum logic [1:0] {I_ACC, I_ZERO, I_ONE, I_P} init_t;
  typedef enum logic [2:0] {D_NONE, D_R1, D_R2, D_NP, D_NQ, D_JAC} dkind_t;

  typedef struct packed {
    logic [4:0] a;
    logic [4:0] b;
    logic       neg;
    logic       dbl;
    init_t      init;
    dkind_t     dk;
    logic [3:0] di;
  } step_t;

  typedef struct packed {
    logic               neg;
    logic               dbl;
    logic               init_en;
    logic signed [31:0] init_val;
    dkind_t             dk;
    logic [3:0]         di;
  } mac_ctl_t;

  typedef struct packed {
    logic               en;
    dkind_t             dk;
    logic [3:0]         di;
    logic signed [31:0] data;
  } wb_t;

  function automatic logic signed [31:0] sat32(logic signed [ACC_W-1:0] v);
    logic signed [31:0] r;
    if (v > 40'sd2147483647) r = 32'sh7fff_ffff;
    else if (v < -40'sd2147483648) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic step_t mk(logic [4:0] a, logic [4:0] b, logic neg, logic dbl,
                               init_t init, dkind_t dk, logic [3:0] di);
    step_t s;
    s.a = a; s.b = b; s.neg = neg; s.dbl = dbl;
    s.init = init; s.dk = dk; s.di = di;
    return s;
  endfunction

  // rotation matrix entries, two products each, doubled
  function automatic step_t rot_step(logic [4:0] base, logic [4:0] j, dkind_t dk);
    logic [4:0] x, y, z, w;
    step_t s;
    x = base;
    y = base + 5'd1;
    z = base + 5'd2;
    w = base + 5'd3;
    unique case (j)
      5'd0: s = mk(y, y, 1'b1, 1'b1, I_ONE, D_NONE, 4'd0);
      5'd1: s = mk(z, z, 1'b1, 1'b1, I_ACC, dk, 4'd0);
      5'd2: s = mk(x, y, 1'b0, 1'b1, I_ZERO, D_NONE, 4'd0);
      5'd3: s = mk(z, w, 1'b1, 1'b1, I_ACC, dk, 4'd1);
      5'd4: s = mk(x, z, 1'b0, 1'b1, I_ZERO, D_NONE, 4'd0);
      5'd5: s = mk(y, w, 1'b0, 1'b1, I_ACC, dk, 4'd2);
      5'd6: s = mk(x, y, 1'b0, 1'b1, I_ZERO, D_NONE, 4'd0);
      5'd7: s = mk(z, w, 1'b0, 1'b1, I_ACC, dk, 4'd3);
      5'd8: s = mk(x, x, 1'b1, 1'b1, I_ONE, D_NONE, 4'd0);
      5'd9: s = mk(z, z, 1'b1, 1'b1, I_ACC, dk, 4'd4);
      5'd10: s = mk(y, z, 1'b0, 1'b1, I_ZERO, D_NONE, 4'd0);
      5'd11: s = mk(x, w, 1'b1, 1'b1, I_ACC, dk, 4'd5);
      5'd12: s = mk(x, z, 1'b0, 1'b1, I_ZERO, D_NONE, 4'd0);
      5'd13: s = mk(y, w, 1'b1, 1'b1, I_ACC, dk, 4'd6);
      5'd14: s = mk(y, z, 1'b0, 1'b1, I_ZERO, D_NONE, 4'd0);
      5'd15: s = mk(x, w, 1'b0, 1'b1, I_ACC, dk, 4'd7);
      5'd16: s = mk(x, x, 1'b1, 1'b1, I_ONE, D_NONE, 4'd0);
      5'd17: s = mk(y, y, 1'b1, 1'b1, I_ACC, dk, 4'd8);
      default: s = mk(x, x, 1'b0, 1'b0, I_ACC, D_NONE, 4'd0);
    endcase
    return s;
  endfunction

  function automatic step_t prog(logic [PC_W-1:0] pc);
    step_t s;
    if (pc < PC_R2) begin
      s = rot_step(SRC_Q1X, pc[4:0], D_R1);
    end else if (pc < PC_QUAT) begin
      s = rot_step(SRC_Q2X, 5'(pc - PC_R2), D_R2);
    end else begin
      unique case (pc)
        // hamilton product, scalar first
        7'd36: s = mk(SRC_Q1W, SRC_Q2W, 1'b0, 1'b0, I_ZERO, D_NONE, 4'd0);
        7'd37: s = mk(SRC_Q1X, SRC_Q2X, 1'b1, 1'b0, I_ACC, D_NONE, 4'd0);
        7'd38: s = mk(SRC_Q1Y, SRC_Q2Y, 1'b1, 1'b0, I_ACC, D_NONE, 4'd0);
        7'd39: s = mk(SRC_Q1Z, SRC_Q2Z, 1'b1, 1'b0, I_ACC, D_NQ, 4'd3);
        7'd40: s = mk(SRC_Q1W, SRC_Q2X, 1'b0, 1'b0, I_ZERO, D_NONE, 4'd0);
        7'd41: s = mk(SRC_Q1X, SRC_Q2W, 1'b0, 1'b0, I_ACC, D_NONE, 4'd0);
        7'd42: s = mk(SRC_Q1Y, SRC_Q2Z, 1'b0, 1'b0, I_ACC, D_NONE, 4'd0);
        7'd43: s = mk(SRC_Q1Z, SRC_Q2Y, 1'b1, 1'b0, I_ACC, D_NQ, 4'd0);
        7'd44: s = mk(SRC_Q1W, SRC_Q2Y, 1'b0, 1'b0, I_ZERO, D_NONE, 4'd0);
        7'd45: s = mk(SRC_Q1X, SRC_Q2Z, 1'b1, 1'b0, I_ACC, D_NONE, 4'd0);
        7'd46: s = mk(SRC_Q1Y, SRC_Q2W, 1'b0, 1'b0, I_ACC, D_NONE, 4'd0);
        7'd47: s = mk(SRC_Q1Z, SRC_Q2X, 1'b0, 1'b0, I_ACC, D_NQ, 4'd1);
        7'd48: s = mk(SRC_Q1W, SRC_Q2Z, 1'b0, 1'b0, I_ZERO, D_NONE, 4'd0);
        7'd49: s = mk(SRC_Q1X, SRC_Q2Y, 1'b0, 1'b0, I_ACC, D_NONE, 4'd0);
        7'd50: s = mk(SRC_Q1Y, SRC_Q2X, 1'b1, 1'b0, I_ACC, D_NONE, 4'd0);
        7'd51: s = mk(SRC_Q1Z, SRC_Q2W, 1'b0, 1'b0, I_ACC, D_NQ, 4'd2);
        // position p1 + R1 p2
        7'd52: s = mk(SRC_R1 + 5'd0, SRC_P2X, 1'b0, 1'b0, I_P, D_NONE, 4'd0);
        7'd53: s = mk(SRC_R1 + 5'd1, SRC_P2Y, 1'b0, 1'b0, I_ACC, D_NONE, 4'd0);
        7'd54: s = mk(SRC_R1 + 5'd2, SRC_P2Z, 1'b0, 1'b0, I_ACC, D_NP, 4'd0);
        7'd55: s = mk(SRC_R1 + 5'd3, SRC_P2X, 1'b0, 1'b0, I_P, D_NONE, 4'd1);
        7'd56: s = mk(SRC_R1 + 5'd4, SRC_P2Y, 1'b0, 1'b0, I_ACC, D_NONE, 4'd0);
        7'd57: s = mk(SRC_R1 + 5'd5, SRC_P2Z, 1'b0, 1'b0, I_ACC, D_NP, 4'd1);
        7'd58: s = mk(SRC_R1 + 5'd6, SRC_P2X, 1'b0, 1'b0, I_P, D_NONE, 4'd2);
        7'd59: s = mk(SRC_R1 + 5'd7, SRC_P2Y, 1'b0, 1'b0, I_ACC, D_NONE, 4'd0);
        7'd60: s = mk(SRC_R1 + 5'd8, SRC_P2Z, 1'b0, 1'b0, I_ACC, D_NP, 4'd2);
        // -R1 skew(p2), zero terms of the skew matrix skipped
        7'd61: s = mk(SRC_R1 + 5'd1, SRC_P2Z, 1'b1, 1'b0, I_ZERO, D_NONE, 4'd0);
        7'd62: s = mk(SRC_R1 + 5'd2, SRC_NP2Y, 1'b1, 1'b0, I_ACC, D_JAC, 4'd0);
        7'd63: s = mk(SRC_R1 + 5'd0, SRC_NP2Z, 1'b1, 1'b0, I_ZERO, D_NONE, 4'd0);
        7'd64: s = mk(SRC_R1 + 5'd2, SRC_P2X, 1'b1, 1'b0, I_ACC, D_JAC, 4'd1);
        7'd65: s = mk(SRC_R1 + 5'd0, SRC_P2Y, 1'b1, 1'b0, I_ZERO, D_NONE, 4'd0);
        7'd66: s = mk(SRC_R1 + 5'd1, SRC_NP2X, 1'b1, 1'b0, I_ACC, D_JAC, 4'd2);
        7'd67: s = mk(SRC_R1 + 5'd4, SRC_P2Z, 1'b1, 1'b0, I_ZERO, D_NONE, 4'd0);
        7'd68: s = mk(SRC_R1 + 5'd5, SRC_NP2Y, 1'b1, 1'b0, I_ACC, D_JAC, 4'd3);
        7'd69: s = mk(SRC_R1 + 5'd3, SRC_NP2Z, 1'b1, 1'b0, I_ZERO, D_NONE, 4'd0);
        7'd70: s = mk(SRC_R1 + 5'd5, SRC_P2X, 1'b1, 1'b0, I_ACC, D_JAC, 4'd4);
        7'd71: s = mk(SRC_R1 + 5'd3, SRC_P2Y, 1'b1, 1'b0, I_ZERO, D_NONE, 4'd0);
        7'd72: s = mk(SRC_R1 + 5'd4, SRC_NP2X, 1'b1, 1'b0, I_ACC, D_JAC, 4'd5);
        7'd73: s = mk(SRC_R1 + 5'd7, SRC_P2Z, 1'b1, 1'b0, I_ZERO, D_NONE, 4'd0);
        7'd74: s = mk(SRC_R1 + 5'd8, SRC_NP2Y, 1'b1, 1'b0, I_ACC, D_JAC, 4'd6);
        7'd75: s = mk(SRC_R1 + 5'd6, SRC_NP2Z, 1'b1, 1'b0, I_ZERO, D_NONE, 4'd0);
        7'd76: s = mk(SRC_R1 + 5'd8, SRC_P2X, 1'b1, 1'b0, I_ACC, D_JAC, 4'd7);
        7'd77: s = mk(SRC_R1 + 5'd6, SRC_P2Y, 1'b1, 1'b0, I_ZERO, D_NONE, 4'd0);
        7'd78: s = mk(SRC_R1 + 5'd7, SRC_NP2X, 1'b1, 1'b0, I_ACC, D_JAC, 4'd8);
        default: s = mk(SRC_Q1X, SRC_Q1X, 1'b0, 1'b0, I_ACC, D_NONE, 4'd0);
      endcase
    end
    return s;
  endfunction

endpackage

/* rtl/pose_delta_composer_unit.sv */
// pose_delta_composer_unit: top level, sequencer, state and result storage
// depends on pdc_pkg and pdc_mac
// sequence: a taken request issues its program steps, drains the multiply and accumulate
// stages, then emits its results from the output register, one per cycle while out_stall is low
// a new request is taken only after every result of the previous one has been emitted; the single
// shared 33x33 multiply-accumulate unit does one product per cycle
// reset: accumulator to zero position and identity orientation, pipeline empty
module pose_delta_composer_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         operation,
  input  logic signed [31:0] dx,
  input  logic signed [31:0] dy,
  input  logic signed [31:0] dz,
  input  logic signed [31:0] qx,
  input  logic signed [31:0] qy,
  input  logic signed [31:0] qz,
  input  logic signed [31:0] qw,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [3:0]         slot,
  output logic signed [31:0] val_a,
  output logic signed [31:0] val_b,
  output logic signed [31:0] val_c,
  output logic signed [31:0] val_d,
  output logic               last
);

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_DRAIN, S_OUT} state_t;

  state_t                          state;
  logic [pdc_pkg::PC_W-1:0]        pc, pc_end;
  logic                            drain_cnt;
  logic [3:0]                      rk, rn;

  // accumulator and working storage
  logic signed [31:0] acc_p [3];
  logic signed [31:0] acc_q [4];
  logic signed [31:0] p2 [3];
  logic signed [31:0] q2 [4];
  logic signed [31:0] r1 [9];
  logic signed [31:0] r2 [9];
  logic signed [31:0] np [3];
  logic signed [31:0] nq [4];
  logic signed [31:0] jac [9];

  logic               in_acc, out_free, issue;
  pdc_pkg::step_t     step;
  pdc_pkg::mac_ctl_t  ctl;
  pdc_pkg::wb_t       wb;
  logic signed [32:0] op_a, op_b;

  logic [3:0]         res_slot;
  logic signed [31:0] res_a, res_b, res_c, res_d;

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign issue    = (state == S_RUN);
  assign step     = pdc_pkg::prog(pc);

  // operand select shared by both multiplier inputs
  function automatic logic signed [32:0] opnd(logic [4:0] s);
    logic signed [32:0] v;
    logic [4:0]         ri;
    ri = s - pdc_pkg::SRC_R1;
    if (s <= pdc_pkg::SRC_Q1W) v = 33'(acc_q[s[1:0]]);
    else if (s <= pdc_pkg::SRC_Q2W) v = 33'(q2[s[1:0]]);
    else if (s == pdc_pkg::SRC_P2X) v = 33'(p2[0]);
    else if (s == pdc_pkg::SRC_P2Y) v = 33'(p2[1]);
    else if (s == pdc_pkg::SRC_P2Z) v = 33'(p2[2]);
    else if (s == pdc_pkg::SRC_NP2X) v = -33'(p2[0]);
    else if (s == pdc_pkg::SRC_NP2Y) v = -33'(p2[1]);
    else if (s == pdc_pkg::SRC_NP2Z) v = -33'(p2[2]);
    else if (ri < 5'd9) v = 33'(r1[ri[3:0]]);
    else v = '0;
    return v;
  endfunction

  always_comb begin
    op_a = opnd(step.a);
    op_b = opnd(step.b);
    ctl.neg = step.neg;
    ctl.dbl = step.dbl;
    ctl.dk  = step.dk;
    ctl.di  = step.di;
    unique case (step.init)
      pdc_pkg::I_ACC: begin
        ctl.init_en = 1'b0;
        ctl.init_val = '0;
      end
      pdc_pkg::I_ZERO: begin
        ctl.init_en = 1'b1;
        ctl.init_val = '0;
      end
      pdc_pkg::I_ONE: begin
        ctl.init_en = 1'b1;
        ctl.init_val = pdc_pkg::ONE_Q30;
      end
      pdc_pkg::I_P: begin
        // position sums start from the old accumulator coordinate
        ctl.init_en = 1'b1;
        ctl.init_val = (step.di[1:0] < 2'd3) ? acc_p[step.di[1:0]] : '0;
      end
      default: begin
        ctl.init_en = 1'b0;
        ctl.init_val = '0;
      end
    endcase
  end

  pdc_mac u_mac (
    .clk   (clk),
    .rst   (rst),
    .issue (issue),
    .op_a  (op_a),
    .op_b  (op_b),
    .ctl   (ctl),
    .wb    (wb)
  );

  // result selection by result number, which equals the slot code
  always_comb begin
    res_slot = rk;
    res_a = '0;
    res_b = '0;
    res_c = '0;
    res_d = '0;
    priority if (rk == pdc_pkg::SLOT_POS) begin
      res_a = np[0]; res_b = np[1]; res_c = np[2];
    end else if (rk == pdc_pkg::SLOT_QUAT) begin
      res_a = nq[0]; res_b = nq[1]; res_c = nq[2]; res_d = nq[3];
    end else if (rk <= 4'd4) begin
      res_a = jac[4'(3*(rk-4'd2))];
      res_b = jac[4'(3*(rk-4'd2)+1)];
      res_c = jac[4'(3*(rk-4'd2)+2)];
    end else if (rk <= 4'd7) begin
      // transpose of R2: column becomes row
      res_a = r2[rk-4'd5]; res_b = r2[rk-4'd2]; res_c = r2[rk+4'd1];
    end else if (rk <= pdc_pkg::SLOT_JAC_LAST) begin
      res_a = r1[4'(3*(rk-4'd8))];
      res_b = r1[4'(3*(rk-4'd8)+1)];
      res_c = r1[4'(3*(rk-4'd8)+2)];
    end else begin
      res_slot = rk;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      pc <= '0;
      drain_cnt <= 1'b0;
      rk <= '0;
      acc_p[0] <= '0;
      acc_p[1] <= '0;
      acc_p[2] <= '0;
      acc_q[0] <= '0;
      acc_q[1] <= '0;
      acc_q[2] <= '0;
      acc_q[3] <= pdc_pkg::ONE_Q30;
    end else begin
      if (!out_stall && !(state == S_OUT && out_free)) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (operation == pdc_pkg::OP_LOAD) begin
              acc_p[0] <= dx; acc_p[1] <= dy; acc_p[2] <= dz;
              acc_q[0] <= qx; acc_q[1] <= qy; acc_q[2] <= qz; acc_q[3] <= qw;
            end else if (operation == pdc_pkg::OP_COMPOSE ||
                         operation == pdc_pkg::OP_COMPOSE_JAC) begin
              p2[0] <= dx; p2[1] <= dy; p2[2] <= dz;
              q2[0] <= qx; q2[1] <= qy; q2[2] <= qz; q2[3] <= qw;
              pc <= '0;
              rk <= '0;
              if (operation == pdc_pkg::OP_COMPOSE_JAC) begin
                pc_end <= pdc_pkg::PC_JAC_END;
                rn <= pdc_pkg::N_COMPOSE_JAC;
              end else begin
                pc_end <= pdc_pkg::PC_POS_END;
                rn <= pdc_pkg::N_COMPOSE;
              end
              state <= S_RUN;
            end
          end
        end
        S_RUN: begin
          pc <= pc + 1'b1;
          if (pc == pc_end) begin
            drain_cnt <= 1'b0;
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          // wait for the multiply and accumulate stages to empty
          drain_cnt <= 1'b1;
          if (drain_cnt) state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            slot  <= res_slot;
            val_a <= res_a;
            val_b <= res_b;
            val_c <= res_c;
            val_d <= res_d;
            last  <= (rk == rn - 4'd1);
            rk <= rk + 4'd1;
            if (rk == rn - 4'd1) begin
              // commit the composed pose with the final result
              acc_p[0] <= np[0]; acc_p[1] <= np[1]; acc_p[2] <= np[2];
              acc_q[0] <= nq[0]; acc_q[1] <= nq[1]; acc_q[2] <= nq[2]; acc_q[3] <= nq[3];
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end

    // write-back from the shared unit
    if (wb.en) begin
      unique case (wb.dk)
        pdc_pkg::D_R1:  r1[wb.di]  <= wb.data;
        pdc_pkg::D_R2:  r2[wb.di]  <= wb.data;
        pdc_pkg::D_NP:  np[wb.di[1:0]] <= wb.data;
        pdc_pkg::D_NQ:  nq[wb.di[1:0]] <= wb.data;
        pdc_pkg::D_JAC: jac[wb.di] <= wb.data;
        default: ;
      endcase
    end
  end

  // the shared unit only writes back during a compose run
  a_wb_busy: assert property (@(posedge clk) disable iff (rst)
    wb.en |-> (state == S_RUN || state == S_DRAIN))
    else $error("write-back outside a compose run");

  // a final result is always the quaternion or the last R1 row
  a_last_slot: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last) |-> (slot == pdc_pkg::SLOT_QUAT || slot == pdc_pkg::SLOT_JAC_LAST))
    else $error("last flag on wrong slot");

  // result counter never passes the run length while emitting
  a_rk_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT) |-> (rk < rn))
    else $error("result counter overrun");

  // a new request is only taken after the previous run has emitted everything
  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && out_free && rk == rn - 4'd1) |=> (state == S_IDLE))
    else $error("sequencer did not return to idle");

endmodule

/* rtl/pdc_mac.sv */
// pdc_mac: shared multiply, round and accumulate pipeline of the pose composer
// depends on pdc_pkg
module pdc_mac (
  input  logic                clk,
  input  logic                rst,
  input  logic                issue,
  input  logic signed [32:0]  op_a,
  input  logic signed [32:0]  op_b,
  input  pdc_pkg::mac_ctl_t   ctl,
  output pdc_pkg::wb_t        wb
);

  logic                              v1, v2;
  logic signed [32:0]                oa, ob;
  pdc_pkg::mac_ctl_t                 c1, c2;
  logic signed [65:0]                prod;
  logic signed [65:0]                rnd;
  logic signed [pdc_pkg::ACC_W-1:0]  acc, acc_next, term, base;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= issue;
      v2 <= v1;
    end
    if (issue) begin
      oa <= op_a;
      ob <= op_b;
      c1 <= ctl;
    end
    if (v1) begin
      prod <= oa * ob;
      c2 <= c1;
    end
    if (v2) acc <= acc_next;
  end

  // round half up at bit 30, then optional negate and doubling
  always_comb begin
    rnd = prod + 66'sd536870912;
    term = pdc_pkg::ACC_W'($signed(rnd[65:30]));
    if (c2.neg) term = -term;
    if (c2.dbl) term = term <<< 1;
    base = c2.init_en ? pdc_pkg::ACC_W'(c2.init_val) : acc;
    acc_next = base + term;
    wb.en = v2 && (c2.dk != pdc_pkg::D_NONE);
    wb.dk = c2.dk;
    wb.di = c2.di;
    wb.data = pdc_pkg::sat32(acc_next);
  end

endmodule

/* test/pose_delta_composer_unit_test.sv */
// pose_delta_composer_unit_test: self-checking bench for the pose delta composer
// depends on pdc_pkg and pose_delta_composer_unit; predicts each result in-bench
`timescale 1ns / 100ps

module pose_delta_composer_unit_test;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int MAX_CYCLES = 400000;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] px, py, pz, ox, oy, oz, ow;
  } delta_t;

  typedef struct packed {
    logic [3:0]         slot;
    logic signed [31:0] a, b, c, d;
    logic               last;
  } pose_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] operation = '0;
  logic signed [31:0] dx = '0, dy = '0, dz = '0, qx = '0, qy = '0, qz = '0, qw = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [3:0] slot;
  logic signed [31:0] val_a, val_b, val_c, val_d;
  logic last;

  pose_delta_composer_unit dut (.*);

  delta_t    pending_deltas[$];
  pose_res_t expected_results[$];
  int        mismatches = 0;
  int        cycles = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;

  // accumulator copy kept by the predictor
  logic signed [31:0] track_pos[3];
  logic signed [31:0] track_quat[4];

  initial begin
    forever #10 clk = ~clk;
  end

  // q2.30 product with round half up
  function automatic longint qmul(longint a, longint b);
    return (a * b + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic logic signed [31:0] clip32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fff_ffff;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic void rot_matrix(input logic signed [31:0] q[4],
                                     output logic signed [31:0] r[3][3]);
    longint x, y, z, w, xx, yy, zz, xy, xz, yz, xw, yw, zw, one;
    x = longint'(q[0]); y = longint'(q[1]); z = longint'(q[2]); w = longint'(q[3]);
    one = 64'sd1 <<< 30;
    xx = qmul(x, x); yy = qmul(y, y); zz = qmul(z, z);
    xy = qmul(x, y); xz = qmul(x, z); yz = qmul(y, z);
    xw = qmul(x, w); yw = qmul(y, w); zw = qmul(z, w);
    r[0][0] = clip32(one - 2 * (yy + zz));
    r[0][1] = clip32(2 * (xy - zw));
    r[0][2] = clip32(2 * (xz + yw));
    r[1][0] = clip32(2 * (xy + zw));
    r[1][1] = clip32(one - 2 * (xx + zz));
    r[1][2] = clip32(2 * (yz - xw));
    r[2][0] = clip32(2 * (xz - yw));
    r[2][1] = clip32(2 * (yz + xw));
    r[2][2] = clip32(one - 2 * (xx + yy));
  endfunction

  // predicts results of one accepted request and advances the accumulator
  function automatic void compose_predict(delta_t t);
    logic signed [31:0] q2[4], r1[3][3], r2[3][3], np[3], nq[4];
    longint p2[3], sk[3][3], s, x1, y1, z1, w1, x2, y2, z2, w2;
    pose_res_t e;
    p2[0] = longint'(t.px); p2[1] = longint'(t.py); p2[2] = longint'(t.pz);
    q2[0] = t.ox; q2[1] = t.oy; q2[2] = t.oz; q2[3] = t.ow;
    if (t.op == OP_UNUSED) return;
    if (t.op == pdc_pkg::OP_LOAD) begin
      for (int i = 0; i < 3; i++) track_pos[i] = 32'(p2[i]);
      for (int i = 0; i < 4; i++) track_quat[i] = q2[i];
      return;
    end
    rot_matrix(track_quat, r1);
    rot_matrix(q2, r2);
    for (int i = 0; i < 3; i++) begin
      s = longint'(track_pos[i]);
      for (int k = 0; k < 3; k++) s += qmul(longint'(r1[i][k]), p2[k]);
      np[i] = clip32(s);
    end
    x1 = longint'(track_quat[0]); y1 = longint'(track_quat[1]);
    z1 = longint'(track_quat[2]); w1 = longint'(track_quat[3]);
    x2 = longint'(q2[0]); y2 = longint'(q2[1]); z2 = longint'(q2[2]); w2 = longint'(q2[3]);
    nq[3] = clip32(qmul(w1, w2) - qmul(x1, x2) - qmul(y1, y2) - qmul(z1, z2));
    nq[0] = clip32(qmul(w1, x2) + qmul(x1, w2) + qmul(y1, z2) - qmul(z1, y2));
    nq[1] = clip32(qmul(w1, y2) - qmul(x1, z2) + qmul(y1, w2) + qmul(z1, x2));
    nq[2] = clip32(qmul(w1, z2) + qmul(x1, y2) - qmul(y1, x2) + qmul(z1, w2));
    e = '{pdc_pkg::SLOT_POS, np[0], np[1], np[2], 32'sd0, 1'b0};
    expected_results.push_back(e);
    e = '{pdc_pkg::SLOT_QUAT, nq[0], nq[1], nq[2], nq[3], t.op == pdc_pkg::OP_COMPOSE};
    expected_results.push_back(e);
    if (t.op == pdc_pkg::OP_COMPOSE_JAC) begin
      sk[0][0] = 0;      sk[0][1] = -p2[2]; sk[0][2] = p2[1];
      sk[1][0] = p2[2];  sk[1][1] = 0;      sk[1][2] = -p2[0];
      sk[2][0] = -p2[1]; sk[2][1] = p2[0];  sk[2][2] = 0;
      for (int i = 0; i < 3; i++) begin
        e = '{4'(pdc_pkg::SLOT_QUAT + 1 + i), 32'sd0, 32'sd0, 32'sd0, 32'sd0, 1'b0};
        for (int j = 0; j < 3; j++) begin
          s = 0;
          for (int k = 0; k < 3; k++) s += qmul(longint'(r1[i][k]), sk[k][j]);
          if (j == 0) e.a = clip32(-s);
          else if (j == 1) e.b = clip32(-s);
          else e.c = clip32(-s);
        end
        expected_results.push_back(e);
      end
      // transposed r2 rows are its columns
      for (int i = 0; i < 3; i++) begin
        e = '{4'(pdc_pkg::SLOT_QUAT + 4 + i), r2[0][i], r2[1][i], r2[2][i], 32'sd0, 1'b0};
        expected_results.push_back(e);
      end
      for (int i = 0; i < 3; i++) begin
        e = '{4'(pdc_pkg::SLOT_QUAT + 7 + i), r1[i][0], r1[i][1], r1[i][2], 32'sd0,
              4'(pdc_pkg::SLOT_QUAT + 7 + i) == pdc_pkg::SLOT_JAC_LAST};
        expected_results.push_back(e);
      end
    end
    track_pos = np;
    track_quat = nq;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    mismatches++;
  endtask

  // driver: presents queued requests, holds payload while stalled
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (!in_valid || !in_stall) begin
        if (in_valid) begin
          void'(pending_deltas.pop_front());
        end
        if (in_valid && pending_deltas.size() == 0) begin
          in_valid <= 1'b0;
        end else if (pending_deltas.size() > (in_valid ? 0 : 0) &&
                     !(in_valid && pending_deltas.size() == 0)) begin
          if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
          end else begin
            in_valid <= 1'b1;
            operation <= pending_deltas[0].op;
            dx <= pending_deltas[0].px;
            dy <= pending_deltas[0].py;
            dz <= pending_deltas[0].pz;
            qx <= pending_deltas[0].ox;
            qy <= pending_deltas[0].oy;
            qz <= pending_deltas[0].oz;
            qw <= pending_deltas[0].ow;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // prediction taken at acceptance
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      compose_predict('{operation, dx, dy, dz, qx, qy, qz, qw});
    end
  end

  // monitor: compares each accepted result with the oldest expectation
  always @(posedge clk) begin
    pose_res_t e;
    cycles <= cycles + 1;
    out_stall <= !rst && ($urandom_range(99) < recv_stall_pct);
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result, slot", slot, -1);
      end else begin
        e = expected_results.pop_front();
        if (slot !== e.slot) report_mismatch("slot", slot, e.slot);
        if (val_a !== e.a) report_mismatch("val_a", val_a, e.a);
        if (val_b !== e.b) report_mismatch("val_b", val_b, e.b);
        if (val_c !== e.c) report_mismatch("val_c", val_c, e.c);
        if (val_d !== e.d) report_mismatch("val_d", val_d, e.d);
        if (last !== e.last) report_mismatch("last", last, e.last);
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    if (cycles > MAX_CYCLES) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic logic signed [31:0] edge_word();
    case ($urandom_range(5))
      0: return 32'sh7fff_ffff;
      1: return 32'sh8000_0000;
      2: return 32'sd0;
      3: return pdc_pkg::ONE_Q30;
      4: return -pdc_pkg::ONE_Q30;
      default: return $urandom;
    endcase
  endfunction

  // random operation with edge-value, fully random or near-unit operands, the last a small perturbation
  function automatic delta_t random_delta();
    delta_t t;
    int r;
    r = $urandom_range(99);
    t.op = (r < 12) ? pdc_pkg::OP_LOAD : (r < 55) ? pdc_pkg::OP_COMPOSE :
           (r < 95) ? pdc_pkg::OP_COMPOSE_JAC : OP_UNUSED;
    if ($urandom_range(3) == 0) begin
      t.px = edge_word(); t.py = edge_word(); t.pz = edge_word();
      t.ox = edge_word(); t.oy = edge_word(); t.oz = edge_word(); t.ow = edge_word();
    end else if ($urandom_range(2) == 0) begin
      t.px = $urandom; t.py = $urandom; t.pz = $urandom;
      t.ox = $urandom; t.oy = $urandom; t.oz = $urandom; t.ow = $urandom;
    end else begin
      t.px = $signed($urandom_range(2 ** 22)) - (2 ** 21);
      t.py = $signed($urandom_range(2 ** 22)) - (2 ** 21);
      t.pz = $signed($urandom_range(2 ** 22)) - (2 ** 21);
      t.ox = $signed($urandom_range(2 ** 27)) - (2 ** 26);
      t.oy = $signed($urandom_range(2 ** 27)) - (2 ** 26);
      t.oz = $signed($urandom_range(2 ** 27)) - (2 ** 26);
      t.ow = pdc_pkg::ONE_Q30 - $signed($urandom_range(2 ** 25));
    end
    return t;
  endfunction

  task automatic wait_drained();
    while (pending_deltas.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  initial begin
    track_pos = '{32'sd0, 32'sd0, 32'sd0};
    track_quat = '{32'sd0, 32'sd0, 32'sd0, pdc_pkg::ONE_Q30};
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    // directed: identity compose, all ops, unused code, extremes, load then compose
    pending_deltas.push_back('{pdc_pkg::OP_COMPOSE, 32'sd65536, -32'sd65536, 32'sd3,
                               0, 0, 0, pdc_pkg::ONE_Q30});
    pending_deltas.push_back('{pdc_pkg::OP_COMPOSE_JAC, 32'sd1000, 32'sd2000, -32'sd3000,
                               32'sd0, 32'sd0, 32'sh2d41_3ccd, 32'sh2d41_3ccd});
    pending_deltas.push_back('{OP_UNUSED, -1, -1, -1, -1, -1, -1, -1});
    pending_deltas.push_back('{pdc_pkg::OP_LOAD, 32'sh7fff_ffff, 32'sh8000_0000, 0,
                               0, pdc_pkg::ONE_Q30, 0, 0});
    pending_deltas.push_back('{pdc_pkg::OP_COMPOSE_JAC, 32'sh7fff_ffff, 32'sh7fff_ffff,
                               32'sh8000_0000, 0, 0, pdc_pkg::ONE_Q30, 0});
    pending_deltas.push_back('{pdc_pkg::OP_COMPOSE_JAC, 32'sh8000_0000, 32'sh8000_0000,
                               32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000,
                               32'sh7fff_ffff, 32'sh8000_0000});
    pending_deltas.push_back('{pdc_pkg::OP_COMPOSE, -1, -1, -1, -1, -1, -1, -1});
    pending_deltas.push_back('{pdc_pkg::OP_LOAD, 32'sh8000_0000, 32'sh8000_0000,
                               32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                               32'sh8000_0000, 32'sh8000_0000});
    pending_deltas.push_back('{pdc_pkg::OP_COMPOSE_JAC, 0, 0, 0, 32'sh8000_0000,
                               32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000});
    pending_deltas.push_back('{pdc_pkg::OP_LOAD, 0, 0, 0, 0, 0, 0, pdc_pkg::ONE_Q30});
    pending_deltas.push_back('{pdc_pkg::OP_COMPOSE, 32'sh5555_5555, 32'sh2aaa_aaaa,
                               32'sh1234_5678, 32'sh0000_ffff, 32'sh3fff_0000,
                               32'sh0f0f_0f0f, 32'sh3000_0000});
    wait_drained();
    // random phases: free run, slow sender, slow receiver, both slow
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1) ? 79 : (ph == 3) ? 12 : 0;
      recv_stall_pct = (ph == 2) ? 79 : (ph == 3) ? 12 : 0;
      for (int n = 0; n < 33; n++) pending_deltas.push_back(random_delta());
      wait_drained();
    end
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
